@@ rtl/core/falt_pkg.sv @@
// Shared types and constants for the failed-attempt lockout table.
// Used by falt_ctrl, falt_dp and failed_attempt_lockout_table_unit.
`default_nettype none

package falt_pkg;

  localparam int unsigned DEF_ENTRIES   = 16;
  localparam int unsigned DEF_KEY_BYTES = 8;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned KEY_BYTE_N = KEY_W / 8;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned SECS_W     = 17;
  localparam int unsigned LOCK_MS_W  = 27;
  localparam int unsigned MS_PER_S   = 1000;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SECS_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(5);
  localparam logic [SECS_W-1:0]  SECS_RST  = SECS_W'(300);

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_FAIL  = 2'd1,
    OP_RESET = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTEMPT_LIMIT = 2'd0,
    REG_LOCK_SECONDS  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [KEY_W-1:0]  user_key;
    logic [LEN_W-1:0]  user_length;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              locked;
    logic [TIME_W-1:0] remaining_ms;
    logic              expired;
    logic              just_locked;
    logic [CNT_W-1:0]  attempt_count;
    logic [SLOT_W-1:0] slot_index;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bypass;
    logic hit;
    logic scan_end;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/falt_ctrl.sv @@
// Sequencer for the lockout table: accept, scan, update, reply.
// Depends on falt_pkg for the command and status structs.
`default_nettype none

module falt_ctrl import falt_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       reply_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_REPLY  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // zero length and unused opcode skip the table
          state_d = stat_i.bypass ? ST_REPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.hit || stat_i.scan_end) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_REPLY;
      ST_REPLY:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load   = accept;
  assign cmd_o.scan   = (state_q == ST_SCAN);
  assign cmd_o.update = (state_q == ST_UPDATE);
  assign busy_o       = (state_q != ST_IDLE);
  assign reply_o      = (state_q == ST_REPLY);

endmodule

`default_nettype wire

@@ rtl/core/falt_dp.sv @@
// Datapath for the lockout table: key memory scan, slot claim, count/deadline update.
// Depends on falt_pkg; driven by falt_ctrl through ctrl_cmd_t.
`default_nettype none

module falt_dp import falt_pkg::*; #(
  parameter int unsigned ENTRIES   = DEF_ENTRIES,
  parameter int unsigned KEY_BYTES = DEF_KEY_BYTES
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  req_t                  req_i,
  input  wire                   cfg_valid_i,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  output res_t                  res_o
);

  localparam int unsigned IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ENT_W = KEY_W + CNT_W + TIME_W;
  localparam int unsigned SUM_W = TIME_W + 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  // configuration
  logic [LIMIT_W-1:0]   limit_q;
  logic [SECS_W-1:0]    secs_q;
  logic [LOCK_MS_W-1:0] lock_ms_q;

  // table: valid bits in flops, key/count/deadline in memory
  logic [ENTRIES-1:0] valid_q;
  logic [ENT_W-1:0]   mem_q [ENTRIES];
  logic [ENT_W-1:0]   rd_q;

  // scan control
  logic [IW-1:0] issue_q, cmp_idx_q, free_idx_q, slot_q;
  logic          issue_on_q, cmp_live_q, free_found_q, full_q;

  // captured item and slot contents
  logic [1:0]        op_q;
  logic [KEY_W-1:0]  key_q;
  logic [TIME_W-1:0] now_q;
  logic [CNT_W-1:0]  attempts_q;
  logic [TIME_W-1:0] deadline_q;
  res_t              res_q;

  logic [KEY_W-1:0]  key_m;
  logic [KEY_W-1:0]  rd_key;
  logic [CNT_W-1:0]  rd_att;
  logic [TIME_W-1:0] rd_dl;
  logic              hit, scan_end, claim, we;
  logic [IW-1:0]     waddr;
  logic [ENT_W-1:0]  wdata;
  logic [CNT_W-1:0]  att_inc, att_n;
  logic [TIME_W-1:0] dl_n, dl_set;
  logic [SUM_W-1:0]  sum;
  logic [IW+SLOT_W-1:0] slot_ext;
  res_t              upd_res, byp_res;
  logic              op_known;

  // zero-pad the key beyond its length
  always_comb begin
    key_m = '0;
    for (int b = 0; b < KEY_BYTE_N; b++) begin
      if ((b < KEY_BYTES) && (LEN_W'(b) < req_i.user_length)) begin
        key_m[8*b +: 8] = req_i.user_key[8*b +: 8];
      end
    end
  end

  assign op_known = (req_i.opcode == OP_QUERY) || (req_i.opcode == OP_FAIL) ||
                    (req_i.opcode == OP_RESET);

  always_comb begin
    byp_res        = '0;
    byp_res.status = (req_i.user_length == '0) ? STATUS_REJECT : STATUS_DONE;
  end

  assign rd_key = rd_q[ENT_W-1 -: KEY_W];
  assign rd_att = rd_q[TIME_W +: CNT_W];
  assign rd_dl  = rd_q[TIME_W-1:0];

  assign hit      = cmp_live_q && valid_q[cmp_idx_q] && (rd_key == key_q);
  assign scan_end = cmp_live_q && (cmp_idx_q == LAST);
  assign claim    = cmd_i.scan && scan_end && !hit && free_found_q;

  assign stat_o.bypass   = (req_i.user_length == '0) || !op_known;
  assign stat_o.hit      = hit;
  assign stat_o.scan_end = scan_end;

  // update of the found slot
  assign att_inc  = (attempts_q == '1) ? attempts_q : attempts_q + 1'b1;
  assign sum      = {1'b0, now_q} + SUM_W'(lock_ms_q);
  assign dl_set   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign slot_ext = {{SLOT_W{1'b0}}, slot_q};

  always_comb begin
    upd_res = '0;
    att_n   = attempts_q;
    dl_n    = deadline_q;
    if (full_q) begin
      upd_res.status = STATUS_FULL;
    end else begin
      upd_res.status = STATUS_DONE;
      case (op_q)
        OP_QUERY: begin
          if (deadline_q != '0) begin
            if (now_q < deadline_q) begin
              upd_res.locked       = 1'b1;
              upd_res.remaining_ms = deadline_q - now_q;
            end else begin
              att_n           = '0;
              dl_n            = '0;
              upd_res.expired = 1'b1;
            end
          end
        end
        OP_FAIL: begin
          att_n = att_inc;
          if (att_n >= CNT_W'(limit_q)) begin
            dl_n                = dl_set;
            upd_res.just_locked = 1'b1;
          end
        end
        OP_RESET: begin
          att_n = '0;
          dl_n  = '0;
        end
        default: ;
      endcase
      upd_res.attempt_count = att_n;
      upd_res.slot_index    = slot_ext[SLOT_W-1:0];
    end
  end

  assign we    = claim || (cmd_i.update && !full_q);
  assign waddr = claim ? free_idx_q : slot_q;
  assign wdata = claim ? {key_q, {CNT_W{1'b0}}, {TIME_W{1'b0}}} : {key_q, att_n, dl_n};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
      secs_q  <= SECS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ATTEMPT_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_LOCK_SECONDS:  secs_q  <= cfg_data_i[SECS_W-1:0];
        default: ;
      endcase
    end
  end

  // seconds to milliseconds, registered ahead of the deadline add
  always_ff @(posedge clk_i) begin
    lock_ms_q <= LOCK_MS_W'(secs_q) * LOCK_MS_W'(MS_PER_S);
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[issue_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      issue_q      <= '0;
      issue_on_q   <= 1'b0;
      cmp_idx_q    <= '0;
      cmp_live_q   <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      full_q       <= 1'b0;
    end else begin
      cmp_live_q <= cmd_i.scan && issue_on_q;
      cmp_idx_q  <= issue_q;
      if (cmd_i.load) begin
        issue_q      <= '0;
        issue_on_q   <= 1'b1;
        free_found_q <= 1'b0;
        full_q       <= 1'b0;
      end else if (cmd_i.scan) begin
        if (issue_on_q) begin
          // note the lowest free slot as addresses go out
          if (!free_found_q && !valid_q[issue_q]) begin
            free_found_q <= 1'b1;
            free_idx_q   <= issue_q;
          end
          if (issue_q == LAST) begin
            issue_on_q <= 1'b0;
          end else begin
            issue_q <= issue_q + 1'b1;
          end
        end
        if (scan_end && !hit && !free_found_q) begin
          full_q <= 1'b1;
        end
      end
      if (claim) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_i.opcode;
      key_q <= key_m;
      now_q <= req_i.now_ms;
      res_q <= byp_res;
    end else if (cmd_i.scan) begin
      if (hit) begin
        slot_q     <= cmp_idx_q;
        attempts_q <= rd_att;
        deadline_q <= rd_dl;
      end else if (claim) begin
        slot_q     <= free_idx_q;
        attempts_q <= '0;
        deadline_q <= '0;
      end
    end else if (cmd_i.update) begin
      res_q <= upd_res;
    end
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_claim_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    claim |-> !valid_q[free_idx_q])
    else $error("claimed slot already valid");

  a_scan_end_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && scan_end) |-> !issue_on_q)
    else $error("scan ended with reads still to issue");

  a_locked_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(cmd_i.update) && res_q.locked) |-> (res_q.remaining_ms != '0))
    else $error("locked result with zero remaining time");
`endif

endmodule

`default_nettype wire

@@ rtl/core/failed_attempt_lockout_table_unit.sv @@
// Top level of the failed-attempt lockout table: controller plus datapath.
// Depends on falt_pkg, falt_ctrl and falt_dp.
//
// An item is taken when start is high and busy is low; its single result
// appears on res_o for one cycle with result_valid_o high and cannot be held
// off. Zero-length keys and the unused opcode answer in the cycle after accept
// and free the block after the reply. Other items scan the key memory one slot
// per cycle (one read port); a match ends the scan, and no match (new key or
// full table) means every slot is scanned. The update state follows, then the
// reply state strobes the result, after which the block takes the next item.
// Slot valid bits clear at reset, so no clearing pass is needed. The config
// port is always ready; write it only while busy is low.
`default_nettype none

module failed_attempt_lockout_table_unit import falt_pkg::*; #(
  parameter int unsigned ENTRIES   = DEF_ENTRIES,
  parameter int unsigned KEY_BYTES = DEF_KEY_BYTES
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  result_valid_o,
  output res_t                  res_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  falt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .reply_o (result_valid_o)
  );

  falt_dp #(
    .ENTRIES   (ENTRIES),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_failed_attempt_lockout_table_unit.sv @@
// Self-checking testbench for failed_attempt_lockout_table_unit.
// Needs falt_pkg and the RTL; the checker compares every result with a
// lockout-table predictor kept in step with each accepted item.
`default_nettype none

module tb_failed_attempt_lockout_table_unit;
  import falt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]        OP_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [KEY_W-1:0]  KEY_A     = 64'h41;
  localparam logic [KEY_W-1:0]  KEY_B     = 64'h8877_6655_4433_2211;
  localparam logic [KEY_W-1:0]  KEY_C     = 64'hC3_B2A1;
  localparam int unsigned       POOL_N    = 10;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic result_valid_o;
  res_t res_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predicted lockout table and register copies
  logic              slot_valid    [DEF_ENTRIES];
  logic [KEY_W-1:0]  slot_key      [DEF_ENTRIES];
  logic [CNT_W-1:0]  slot_count    [DEF_ENTRIES];
  logic [TIME_W-1:0] slot_deadline [DEF_ENTRIES];
  logic [LIMIT_W-1:0] model_limit;
  logic [SECS_W-1:0]  model_lock_s;

  res_t pending_verdicts [$];
  int unsigned mismatch_count;

  failed_attempt_lockout_table_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [KEY_W-1:0] key_mask(input int unsigned len);
    if (len >= DEF_KEY_BYTES) return '1;
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  function automatic req_t make_req(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                    input int unsigned len, input logic [TIME_W-1:0] now);
    req_t item;
    item.opcode      = op;
    item.user_key    = key;
    item.user_length = LEN_W'(len);
    item.now_ms      = now;
    return item;
  endfunction

  // Apply one item to the predicted table and return its verdict
  function automatic res_t lockout_predict(input req_t item);
    res_t verdict;
    int unsigned len;
    logic [KEY_W-1:0] key;
    logic [TIME_W:0] lock_ms;
    logic [TIME_W:0] sum;
    int slot;
    int free_slot;
    verdict = '0;
    len = 32'(item.user_length);
    if (len == 0) begin
      verdict.status = STATUS_REJECT;
      return verdict;
    end
    if (item.opcode == OP_UNUSED) return verdict;
    if (len > DEF_KEY_BYTES) len = DEF_KEY_BYTES;
    key = item.user_key & key_mask(len);

    slot = -1;
    free_slot = -1;
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      if (slot < 0 && slot_valid[i] && slot_key[i] == key) slot = i;
      if (free_slot < 0 && !slot_valid[i]) free_slot = i;
    end
    if (slot < 0) begin
      if (free_slot < 0) begin
        verdict.status = STATUS_FULL;
        return verdict;
      end
      slot = free_slot;
      slot_valid[slot]    = 1'b1;
      slot_key[slot]      = key;
      slot_count[slot]    = '0;
      slot_deadline[slot] = '0;
    end

    if (item.opcode == OP_QUERY) begin
      if (slot_deadline[slot] != '0) begin
        if (item.now_ms < slot_deadline[slot]) begin
          verdict.locked       = 1'b1;
          verdict.remaining_ms = slot_deadline[slot] - item.now_ms;
        end else begin
          slot_count[slot]    = '0;
          slot_deadline[slot] = '0;
          verdict.expired     = 1'b1;
        end
      end
    end else if (item.opcode == OP_FAIL) begin
      if (slot_count[slot] != COUNT_MAX) slot_count[slot] = slot_count[slot] + 1'b1;
      if (slot_count[slot] >= CNT_W'(model_limit)) begin
        lock_ms = (TIME_W+1)'(model_lock_s);
        lock_ms = lock_ms * MS_PER_S;
        sum = {1'b0, item.now_ms} + lock_ms;
        slot_deadline[slot] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        verdict.just_locked = 1'b1;
      end
    end else begin
      slot_count[slot]    = '0;
      slot_deadline[slot] = '0;
    end

    verdict.attempt_count = slot_count[slot];
    verdict.slot_index    = SLOT_W'(slot);
    return verdict;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : verdict_check
    res_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", 64'(res_o.status), 64'(want.status));
        check_field("locked", 64'(res_o.locked), 64'(want.locked));
        check_field("remaining_ms", 64'(res_o.remaining_ms), 64'(want.remaining_ms));
        check_field("expired", 64'(res_o.expired), 64'(want.expired));
        check_field("just_locked", 64'(res_o.just_locked), 64'(want.just_locked));
        check_field("attempt_count", 64'(res_o.attempt_count), 64'(want.attempt_count));
        check_field("slot_index", 64'(res_o.slot_index), 64'(want.slot_index));
      end
    end
  end

  // Hold start high until the block takes the item; start stays high on return
  task automatic send_item(input req_t item);
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
    pending_verdicts.push_back(lockout_predict(item));
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_verdicts.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_ATTEMPT_LIMIT) model_limit = value[LIMIT_W-1:0];
    else model_lock_s = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned limit, input int unsigned secs);
    pause(1);
    wait_idle();
    write_reg(REG_ATTEMPT_LIMIT, CFG_DATA_W'(limit));
    write_reg(REG_LOCK_SECONDS, CFG_DATA_W'(secs));
  endtask

  task automatic test_directed();
    // reset values of the registers first
    send_item(make_req(OP_QUERY, KEY_A, 1, 0));
    send_item(make_req(OP_FAIL, {$urandom, $urandom}, 0, 5));
    send_item(make_req(OP_UNUSED, KEY_B, 8, 5));
    repeat (5) send_item(make_req(OP_FAIL, KEY_A | ({$urandom, $urandom} & ~key_mask(1)),
                                  1, 1000));
    send_item(make_req(OP_QUERY, KEY_A, 1, 2000));
    send_item(make_req(OP_QUERY, KEY_A, 1, 301_000));
    send_item(make_req(OP_QUERY, KEY_A, 1, 301_001));
    send_item(make_req(OP_FAIL, KEY_B, 15, TIME_MAX - 5));
    send_item(make_req(OP_RESET, KEY_B, 8, 7));

    // deadline saturates at the top of the time range
    set_config(1, 131071);
    send_item(make_req(OP_FAIL, KEY_C | ({$urandom, $urandom} & ~key_mask(3)), 3,
                       TIME_MAX - 5));
    send_item(make_req(OP_QUERY, KEY_C, 3, TIME_MAX - 1));
    send_item(make_req(OP_QUERY, KEY_C, 3, TIME_MAX));

    // limit zero locks on every failure; duration zero puts the deadline at now
    set_config(0, 0);
    send_item(make_req(OP_FAIL, KEY_A, 1, 0));
    send_item(make_req(OP_QUERY, KEY_A, 1, 0));
    send_item(make_req(OP_FAIL, KEY_A, 1, 500));
    send_item(make_req(OP_QUERY, KEY_A, 1, 500));
  endtask

  task automatic test_count_below_limit();
    set_config(255, 1);
    // count climbs without locking while under a high limit
    repeat (12) send_item(make_req(OP_FAIL, KEY_A, 1, 5000));
    send_item(make_req(OP_QUERY, KEY_A, 1, 5999));
    send_item(make_req(OP_RESET, KEY_A, 1, 6000));
    send_item(make_req(OP_QUERY, KEY_A, 1, 6001));
  endtask

  task automatic test_random_traffic();
    int unsigned phase_limit [6] = '{3, 1, 255, 0, 5, 2};
    int unsigned phase_secs  [6] = '{2, 1, 86400, 0, 131071, 3};
    logic [KEY_W-1:0] pool_key [POOL_N];
    int unsigned pool_len [POOL_N];
    logic [TIME_W-1:0] clock_ms;
    logic [KEY_W-1:0] key;
    logic [1:0] op;
    int unsigned burst_left;
    int unsigned pick;
    int unsigned roll;
    int unsigned len;
    clock_ms = 10_000;
    burst_left = 0;
    set_config(phase_limit[0], phase_secs[0]);
    // claim a slot for every pooled key before noise fills the table
    for (int i = 0; i < POOL_N; i++) begin
      pool_len[i] = $urandom_range(1, DEF_KEY_BYTES);
      pool_key[i] = {$urandom, $urandom} & key_mask(pool_len[i]);
      send_item(make_req(OP_FAIL, pool_key[i], pool_len[i], clock_ms));
    end
    for (int phase = 0; phase < 6; phase++) begin
      if (phase != 0) set_config(phase_limit[phase], phase_secs[phase]);
      repeat (90) begin
        if (burst_left == 0) begin
          pause($urandom_range(1, 6));
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
        end
        burst_left--;
        if ($urandom_range(0, 99) < 8) begin
          // noise: any key, length, opcode and time
          send_item(make_req(2'($urandom_range(0, 3)), {$urandom, $urandom},
                             $urandom_range(0, 15), TIME_W'({$urandom, $urandom})));
        end else begin
          pick = $urandom_range(0, POOL_N - 1);
          roll = $urandom_range(0, 99);
          if (roll < 50) op = OP_FAIL;
          else if (roll < 82) op = OP_QUERY;
          else if (roll < 95) op = OP_RESET;
          else op = OP_UNUSED;
          len = pool_len[pick];
          if (len == DEF_KEY_BYTES) len = $urandom_range(DEF_KEY_BYTES, 15);
          if ($urandom_range(0, 49) == 0) len = 0;
          key = pool_key[pick] | ({$urandom, $urandom} & ~key_mask(pool_len[pick]));
          roll = $urandom_range(0, 99);
          if (roll < 2) clock_ms = TIME_MAX - $urandom_range(0, 3000);
          else if (roll < 4) clock_ms = TIME_W'($urandom_range(0, 2000));
          else clock_ms = clock_ms + $urandom_range(0, 400);
          send_item(make_req(op, key, len, clock_ms));
        end
      end
    end
  endtask

  task automatic test_table_full();
    set_config(5, 300);
    // fresh keys take the last free slots, then find the table full
    repeat (20) send_item(make_req(OP_FAIL, {$urandom, $urandom}, 8, 1234));
    send_item(make_req(OP_QUERY, KEY_B, 8, 1234));
  endtask

  initial begin
    start       <= 1'b0;
    req_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_ATTEMPT_LIMIT;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    mismatch_count = 0;
    for (int i = 0; i < DEF_ENTRIES; i++) slot_valid[i] = 1'b0;
    model_limit  = LIMIT_RST;
    model_lock_s = SECS_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_count_below_limit();
    test_random_traffic();
    test_table_full();

    pause(1);
    wait_idle();
    repeat (DEF_ENTRIES + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("failed_attempt_lockout_table_unit regression: pass");
    end else begin
      $display("failed_attempt_lockout_table_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("failed_attempt_lockout_table_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
